### design/tmoe_pkg.sv
package tmoe_pkg;

  // operation codes
  typedef enum logic [2:0] {
    CMD_INC   = 3'd0,
    CMD_DEC   = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_OUT   = 3'd4,
    CMD_IN    = 3'd5,
    CMD_LOOPB = 3'd6,
    CMD_LOOPE = 3'd7
  } tmoe_cmd_e;

  // one operation transaction
  typedef struct packed {
    tmoe_cmd_e          cmd;
    logic [7:0]         in_byte;
    logic signed [15:0] jump_offset;
  } tmoe_item_t;

  // one result transaction
  typedef struct packed {
    logic signed [16:0] pc_offset;
    logic [7:0]         out_byte;
    logic               out_valid;
    logic               fault;
  } tmoe_result_t;

  // offset returned by loop begin when the cell is nonzero
  localparam logic signed [16:0] LOOP_SKIP = 17'sd2;

endpackage

### design/tape_machine_op_executor.sv
// Executes one pre-parsed tape machine operation per transaction. An operation is taken
// when start is high and busy is low; its result appears on result_o in the next cycle,
// marked by done_o for exactly one cycle, and cannot be held off. Operations that work
// on the current cell (inc, dec, output, input, loop begin, loop end) leave busy low,
// because the current cell is kept in a register. A pointer move writes the old cell back
// to the tape memory and reads the new cell through its registered read port; busy is
// high while the new cell is loaded. A move that would leave the tape does not raise busy
// and sets a sticky fault; every later operation then returns a fault result until reset.
// The tape needs no clearing pass after reset: a fill mark tracks how many cells from the
// left have ever been written, and cells beyond it read as zero.
module tape_machine_op_executor #(
  parameter int TAPE_CELLS = 32768
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  tmoe_pkg::tmoe_item_t  item_i,
  output logic                  done_o,
  output tmoe_pkg::tmoe_result_t result_o
);
  import tmoe_pkg::*;

  localparam int PTR_W = (TAPE_CELLS > 2) ? $clog2(TAPE_CELLS) : 1;
  localparam int CNT_W = $clog2(TAPE_CELLS + 1);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_LOAD = 1'b1;

  logic             state_q, state_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [7:0]       cur_q, cur_d;
  logic             fault_q, fault_d;
  logic             done_q, done_d;
  tmoe_result_t     result_q, result_d;

  logic             accept;
  logic             mem_we;
  logic [7:0]       rd_data_q;
  logic [7:0]       tape_mem [TAPE_CELLS];

  assign busy   = (state_q == ST_LOAD);
  assign accept = start && !busy;

  // tape memory: write back the cell left behind, read the cell moved to
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tape_mem[ptr_q] <= cur_q;
    end
    rd_data_q <= tape_mem[ptr_d];
  end

  // operation decode and next state
  always_comb begin
    state_d  = ST_RUN;
    ptr_d    = ptr_q;
    fill_d   = fill_q;
    cur_d    = cur_q;
    fault_d  = fault_q;
    done_d   = 1'b0;
    mem_we   = 1'b0;
    result_d = '0;

    if (state_q == ST_LOAD) begin
      // new cell arrives; cells past the fill mark were never written
      cur_d = (CNT_W'(ptr_q) < fill_q) ? rd_data_q : 8'h00;
    end else if (accept) begin
      done_d = 1'b1;
      if (fault_q) begin
        result_d.fault = 1'b1;
      end else begin
        case (item_i.cmd)
          CMD_INC: cur_d = cur_q + 8'd1;
          CMD_DEC: cur_d = cur_q - 8'd1;
          CMD_IN:  cur_d = item_i.in_byte;
          CMD_OUT: begin
            result_d.out_byte  = cur_q;
            result_d.out_valid = 1'b1;
          end
          CMD_LOOPB: begin
            result_d.pc_offset = (cur_q == 8'h00)
                ? ({item_i.jump_offset[15], item_i.jump_offset} - 17'sd1)
                : LOOP_SKIP;
          end
          CMD_LOOPE: begin
            result_d.pc_offset = {item_i.jump_offset[15], item_i.jump_offset} - 17'sd1;
          end
          CMD_LEFT, CMD_RIGHT: begin
            if ((item_i.cmd == CMD_LEFT && ptr_q == '0) ||
                (item_i.cmd == CMD_RIGHT && ptr_q == PTR_W'(TAPE_CELLS - 1))) begin
              fault_d = 1'b1;
            end else begin
              mem_we  = 1'b1;
              state_d = ST_LOAD;
              ptr_d   = (item_i.cmd == CMD_LEFT) ? ptr_q - PTR_W'(1) : ptr_q + PTR_W'(1);
              if (CNT_W'(ptr_q) == fill_q) begin
                fill_d = fill_q + CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
        result_d.fault = fault_d;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      ptr_q   <= '0;
      fill_q  <= '0;
      cur_q   <= 8'h00;
      fault_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      fill_q  <= fill_d;
      cur_q   <= cur_d;
      fault_q <= fault_d;
      done_q  <= done_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (done_d) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### design/tmoe_checker.sv
module tmoe_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   start,
  input logic                   busy,
  input tmoe_pkg::tmoe_item_t   item_i,
  input logic                   done_o,
  input tmoe_pkg::tmoe_result_t result_o
);
  import tmoe_pkg::*;

  // every accepted transaction gives a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted transaction produced no result");

  // no result without an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy))
    else $error("result without a transaction");

  // busy only follows a pointer move and lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start) &&
      ($past(item_i.cmd) == CMD_LEFT || $past(item_i.cmd) == CMD_RIGHT))
    else $error("busy without a pointer move");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // a fault result carries no output byte and no jump
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.fault) |-> (!result_o.out_valid && result_o.pc_offset == 17'sd0))
    else $error("fault result with output or jump");

endmodule

bind tape_machine_op_executor tmoe_checker u_tmoe_checker (.*);

### test/tape_machine_op_executor_tb.sv
`timescale 1ns / 100ps

module tape_machine_op_executor_tb;
  import tmoe_pkg::*;

  localparam int TAPE_CELLS = 32768;

  // tape machine predictor and queue of expected results
  class tape_scoreboard;
    logic [7:0]   cells [TAPE_CELLS];
    logic [14:0]  ptr;
    bit           faulted;
    tmoe_result_t expected_q [$];
    int           failures;

    function new();
      foreach (cells[i]) cells[i] = 8'h00;
      ptr = '0;
      faulted = 1'b0;
      failures = 0;
    endfunction

    // run one accepted operation on the tape and queue its result
    function void note_op(tmoe_item_t op);
      tmoe_result_t r;
      logic [16:0]  back;
      r = '0;
      back = {op.jump_offset[15], op.jump_offset} - 17'd1;
      if (faulted) begin
        r.fault = 1'b1;
        expected_q.push_back(r);
        return;
      end
      case (op.cmd)
        CMD_INC:   cells[ptr] = cells[ptr] + 8'd1;
        CMD_DEC:   cells[ptr] = cells[ptr] - 8'd1;
        CMD_LEFT: begin
          if (ptr == '0) faulted = 1'b1;
          else ptr = ptr - 15'd1;
        end
        CMD_RIGHT: begin
          if (ptr == 15'(TAPE_CELLS - 1)) faulted = 1'b1;
          else ptr = ptr + 15'd1;
        end
        CMD_OUT: begin
          r.out_byte  = cells[ptr];
          r.out_valid = 1'b1;
        end
        CMD_IN:    cells[ptr] = op.in_byte;
        CMD_LOOPB: r.pc_offset = (cells[ptr] == 8'h00) ? back : LOOP_SKIP;
        CMD_LOOPE: r.pc_offset = back;
        default:   ;
      endcase
      r.fault = faulted;
      expected_q.push_back(r);
    endfunction

    // compare one result against the oldest expectation
    function void check_result(tmoe_result_t got);
      tmoe_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: pc_offset %0d out_byte %02h out_valid %0b fault %0b",
                   got.pc_offset, got.out_byte, got.out_valid, got.fault);
        return;
      end
      want = expected_q.pop_front();
      if (got.pc_offset !== want.pc_offset || got.out_byte !== want.out_byte ||
          got.out_valid !== want.out_valid || got.fault !== want.fault) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected pc_offset %0d out_byte %02h out_valid %0b fault %0b,",
                   want.pc_offset, want.out_byte, want.out_valid, want.fault,
                   " got %0d %02h %0b %0b",
                   got.pc_offset, got.out_byte, got.out_valid, got.fault);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  tmoe_item_t   item_i;
  logic         done_o;
  tmoe_result_t result_o;

  tape_scoreboard sb;
  int             gen_ptr;
  int             items_sent;
  int             idle_pct;

  tape_machine_op_executor #(.TAPE_CELLS(TAPE_CELLS)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // monitor: note accepted operations, then check results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_op(item_i);
      if (done_o) sb.check_result(result_o);
    end
  end

  // hang guard
  initial begin
    #10_000_000;
    $display("tape_machine_op_executor_tb: errors");
    $finish;
  end

  function automatic tmoe_item_t mk_op(tmoe_cmd_e cmd, logic [7:0] byte_in,
                                       logic [15:0] jump);
    tmoe_item_t op;
    op.cmd         = cmd;
    op.in_byte     = byte_in;
    op.jump_offset = jump;
    return op;
  endfunction

  // idle the sender: take start low
  task automatic pause_cycle();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // issue one operation transaction and wait until it is taken
  task automatic send_op(input tmoe_item_t op);
    while ($urandom_range(99) < idle_pct) pause_cycle();
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= op;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (op.cmd == CMD_LEFT && gen_ptr > 0) gen_ptr--;
    if (op.cmd == CMD_RIGHT && gen_ptr < TAPE_CELLS - 1) gen_ptr++;
  endtask

  // stop sending until every expected result is back
  task automatic drain();
    pause_cycle();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // random operation, pointer kept inside [0, window] so it never faults
  function automatic tmoe_item_t random_op(int window);
    tmoe_item_t op;
    int         pick;
    op.in_byte     = 8'($urandom_range(255));
    op.jump_offset = 16'($urandom_range(65535));
    pick = $urandom_range(99);
    if (pick < 15) op.cmd = CMD_INC;
    else if (pick < 27) op.cmd = CMD_DEC;
    else if (pick < 40) begin
      if (gen_ptr == 0) op.cmd = CMD_RIGHT;
      else if (gen_ptr >= window) op.cmd = CMD_LEFT;
      else op.cmd = $urandom_range(1) ? CMD_RIGHT : CMD_LEFT;
    end
    else if (pick < 55) op.cmd = CMD_OUT;
    else if (pick < 67) begin
      op.cmd = CMD_IN;
      if ($urandom_range(3) == 0) op.in_byte = 8'h00;
    end
    else if (pick < 84) op.cmd = CMD_LOOPB;
    else op.cmd = CMD_LOOPE;
    return op;
  endfunction

  // counted loop as a program would run it: load, then body until the cell is zero
  task automatic count_loop();
    logic [7:0] count;
    count = 8'($urandom_range(1, 6));
    send_op(mk_op(CMD_IN, count, 16'($urandom)));
    repeat (count) begin
      send_op(mk_op(CMD_LOOPB, 8'($urandom), 16'($urandom)));
      send_op(mk_op(CMD_DEC, 8'($urandom), 16'($urandom)));
      send_op(mk_op(CMD_OUT, 8'($urandom), 16'($urandom)));
      send_op(mk_op(CMD_LOOPE, 8'($urandom), 16'($urandom)));
    end
    send_op(mk_op(CMD_LOOPB, 8'($urandom), 16'($urandom)));
  endtask

  initial begin
    int pct_by_phase [3];
    int window_by_phase [3];
    int target;
    pct_by_phase    = '{0, 61, 8};
    window_by_phase = '{8, 48, 300};
    sb         = new();
    start      = 1'b0;
    item_i     = '0;
    rst_ni     = 1'b0;
    gen_ptr    = 0;
    items_sent = 0;
    idle_pct   = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: wrap, field extremes, both loop begin cases, pointer moves
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_LOOPB, 8'h00, 16'h8000));
    send_op(mk_op(CMD_LOOPE, 8'hFF, 16'h7FFF));
    send_op(mk_op(CMD_LOOPE, 8'h00, 16'h0000));
    send_op(mk_op(CMD_INC,   8'h00, 16'h0000));
    send_op(mk_op(CMD_LOOPB, 8'h00, 16'h0005));
    send_op(mk_op(CMD_DEC,   8'h00, 16'h0000));
    send_op(mk_op(CMD_DEC,   8'h00, 16'h0000));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_INC,   8'h00, 16'h0000));
    send_op(mk_op(CMD_IN,    8'hFF, 16'hFFFF));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_IN,    8'h00, 16'hFFFF));
    send_op(mk_op(CMD_LOOPB, 8'hFF, 16'h7FFF));
    send_op(mk_op(CMD_RIGHT, 8'h00, 16'h0000));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_IN,    8'h5A, 16'h1234));
    send_op(mk_op(CMD_LEFT,  8'h00, 16'h0000));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_RIGHT, 8'h00, 16'h0000));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_LOOPB, 8'h00, 16'hFFFF));
    send_op(mk_op(CMD_LEFT,  8'h00, 16'h0000));
    send_op(mk_op(CMD_LOOPE, 8'h00, 16'h0001));
    drain();

    // random phases with different sender idling and pointer spread
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = pct_by_phase[ph];
      target = items_sent + 630;
      while (items_sent < target) begin
        if ($urandom_range(9) < 2) count_loop();
        else send_op(random_op(window_by_phase[ph]));
      end
      drain();
    end

    // walk back to cell zero, then step off the left end
    idle_pct = 0;
    while (gen_ptr > 0)
      send_op(mk_op(CMD_LEFT, 8'($urandom), 16'($urandom)));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_IN,    8'hC3, 16'h0000));
    send_op(mk_op(CMD_RIGHT, 8'h00, 16'h0000));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_LEFT,  8'h00, 16'h0000));
    send_op(mk_op(CMD_OUT,   8'h00, 16'h0000));
    send_op(mk_op(CMD_LEFT,  8'h00, 16'h0000));

    // everything after the fault is ignored
    idle_pct = 8;
    repeat (24)
      send_op(mk_op(tmoe_cmd_e'($urandom_range(7)), 8'($urandom), 16'($urandom)));
    drain();

    if (sb.failures == 0 && sb.expected_q.size() == 0)
      $display("tape_machine_op_executor_tb: clean");
    else
      $display("tape_machine_op_executor_tb: errors");
    $finish;
  end

endmodule

### files.f
design/tmoe_pkg.sv
design/tape_machine_op_executor.sv
design/tmoe_checker.sv
test/tape_machine_op_executor_tb.sv
